@@ src/two_level_event_counter_assert.svh @@
// ---------------------------------------------------------------------------
// two_level_event_counter assertion macros
// shared property forms for the checker of the completion counter
// ---------------------------------------------------------------------------
`ifndef TWO_LEVEL_EVENT_COUNTER_ASSERT_SVH
`define TWO_LEVEL_EVENT_COUNTER_ASSERT_SVH

// same-cycle implication, masked while reset is high
`define TLEC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while reset is high
`define TLEC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define TLEC_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tlec_pkg.sv @@
// ---------------------------------------------------------------------------
// tlec_pkg
// constants and field widths of the two-level event completion counter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlec_pkg;

  // array sizes
  localparam int NUM_CLUSTERS = 8;
  localparam int EVENT_SLOTS  = 64;
  localparam int LOC_DEPTH    = NUM_CLUSTERS * EVENT_SLOTS;
  localparam int LOC_AW       = (LOC_DEPTH > 1) ? $clog2(LOC_DEPTH) : 1;
  localparam int EV_AW        = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

  // counter and product widths
  localparam int CNT_W  = 48;
  localparam int PROD_W = 32;

  // request field widths
  localparam int CLUSTER_W = 3;
  localparam int EVENT_W   = 6;
  localparam int THR_W     = 8;
  localparam int TRIG_W    = 16;
  localparam int TILES_W   = 16;
  localparam int ITER_W    = 16;

  // request field offsets in tdata
  localparam int CLUSTER_LSB = 0;
  localparam int EVENT_LSB   = CLUSTER_LSB + CLUSTER_W;
  localparam int THR_LSB     = EVENT_LSB + EVENT_W;
  localparam int TRIG_LSB    = THR_LSB + THR_W;
  localparam int TILES_LSB   = TRIG_LSB + TRIG_W;
  localparam int ITER_LSB    = TILES_LSB + TILES_W;
  localparam int IN_BITS     = ITER_LSB + ITER_W;

  // bus widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

endpackage

@@ src/two_level_event_counter.sv @@
// ---------------------------------------------------------------------------
// two_level_event_counter
// cluster-local and global completion counters with a fire flag per request
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one completion request (cluster, event, thresholds, tiles,
//   iteration); m_axis returns exactly one result per request, bit 0 = fired.
//   A request with zero tiles or an out-of-range index changes nothing and
//   returns fired = 0.
//   Requests: a skipped request goes straight to the output register; any
//   other request runs a read-add-write sequence over the two counter
//   memories through one shared adder and one shared multiplier, updating
//   the global count only when the local count equals its target. A new
//   request is taken only after the last result has been registered.
//   Reset: a clearing pass over LOC_DEPTH slots (512 at 8 clusters and 64
//   events) zeroes both memories; s_axis_tready stays low meanwhile.
//   Stall: a result waits in the output register; the next request is still
//   taken, but its result is held back until the receiver takes the first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_level_event_counter (
  input  logic                             clk,
  input  logic                             rst,
  // cluster, event_req, local_threshold, trigger_total, tiles_done, iteration
  input  logic [tlec_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // fired
  output logic [tlec_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready
);

  import tlec_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_LREAD = 6'b000100,
    ST_LADD  = 6'b001000,
    ST_GADD  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t              state, state_next;
  logic [LOC_AW-1:0]   clr_addr;
  logic [LOC_AW-1:0]   slot;
  logic [EV_AW-1:0]    ev_idx;
  logic [THR_W-1:0]    thr;
  logic [TRIG_W-1:0]   trig;
  logic [TILES_W-1:0]  tiles;
  logic [ITER_W-1:0]   iter;
  logic [PROD_W-1:0]   prod;
  logic                fired_pend;
  logic                out_valid;
  logic                out_fired;

  // request fields
  logic [CLUSTER_W-1:0] in_cluster;
  logic [EVENT_W-1:0]   in_event;
  logic [TILES_W-1:0]   in_tiles;
  logic                 in_take;
  logic                 in_skip;
  logic [LOC_AW-1:0]    in_slot;

  // shared units and memory ports
  logic [TRIG_W-1:0]    mul_a;
  logic [PROD_W-1:0]    mul_y;
  logic [CNT_W-1:0]     add_a;
  logic [CNT_W-1:0]     add_b;
  logic [CNT_W-1:0]     add_y;
  logic                 add_hit;
  logic                 out_free;

  logic                 loc_we;
  logic [LOC_AW-1:0]    loc_waddr;
  logic [CNT_W-1:0]     loc_rdata;
  logic                 glb_we;
  logic [EV_AW-1:0]     glb_waddr;
  logic [CNT_W-1:0]     glb_rdata;
  logic [CNT_W-1:0]     cnt_wdata;

  // request unpacking
  assign in_cluster = s_axis_tdata[CLUSTER_LSB +: CLUSTER_W];
  assign in_event   = s_axis_tdata[EVENT_LSB +: EVENT_W];
  assign in_tiles   = s_axis_tdata[TILES_LSB +: TILES_W];
  assign in_take    = s_axis_tvalid && s_axis_tready;
  assign in_skip    = (in_tiles == '0)
                   || (32'(in_cluster) >= NUM_CLUSTERS)
                   || (32'(in_event) >= EVENT_SLOTS);
  assign in_slot    = LOC_AW'(32'(in_cluster) * EVENT_SLOTS + 32'(in_event));

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !out_valid || m_axis_tready;

  // shared multiplier: local target first, then global target
  assign mul_a = (state == ST_LREAD) ? TRIG_W'(thr) : trig;
  assign mul_y = PROD_W'(mul_a) * PROD_W'(iter);

  // shared adder: tiles onto the local count, then one onto the global count
  assign add_a   = (state == ST_LADD) ? loc_rdata : glb_rdata;
  assign add_b   = (state == ST_LADD) ? CNT_W'(tiles) : CNT_W'(1);
  assign add_y   = add_a + add_b;
  assign add_hit = (add_y == CNT_W'(prod));

  // memory write control, clearing pass shares the write ports
  assign cnt_wdata = (state == ST_CLEAR) ? '0 : add_y;
  assign loc_we    = (state == ST_CLEAR) || (state == ST_LADD);
  assign loc_waddr = (state == ST_CLEAR) ? clr_addr : slot;
  assign glb_we    = (state == ST_CLEAR) || (state == ST_GADD);
  assign glb_waddr = (state == ST_CLEAR) ? EV_AW'(clr_addr) : ev_idx;

  tlec_ram #(
    .WIDTH (CNT_W),
    .DEPTH (LOC_DEPTH)
  ) u_local_ram (
    .clk   (clk),
    .we    (loc_we),
    .waddr (loc_waddr),
    .wdata (cnt_wdata),
    .re    (state == ST_LREAD),
    .raddr (slot),
    .rdata (loc_rdata)
  );

  tlec_ram #(
    .WIDTH (CNT_W),
    .DEPTH (EVENT_SLOTS)
  ) u_global_ram (
    .clk   (clk),
    .we    (glb_we),
    .waddr (glb_waddr),
    .wdata (cnt_wdata),
    .re    (state == ST_LREAD),
    .raddr (ev_idx),
    .rdata (glb_rdata)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LOC_AW'(LOC_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_take) state_next = in_skip ? ST_DONE : ST_LREAD;
      end
      ST_LREAD: state_next = ST_LADD;
      ST_LADD: begin
        state_next = add_hit ? ST_GADD : ST_DONE;
      end
      ST_GADD: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + LOC_AW'(1);
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture and working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      slot       <= in_slot;
      ev_idx     <= EV_AW'(in_event);
      thr        <= s_axis_tdata[THR_LSB +: THR_W];
      trig       <= s_axis_tdata[TRIG_LSB +: TRIG_W];
      tiles      <= in_tiles;
      iter       <= s_axis_tdata[ITER_LSB +: ITER_W];
      fired_pend <= 1'b0;
    end
    if (state == ST_LREAD || state == ST_LADD) begin
      prod <= mul_y;
    end
    if (state == ST_GADD) begin
      fired_pend <= add_hit;
    end
    if (state == ST_DONE && out_free) begin
      out_fired <= fired_pend;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_TDATA_W - 1)'(0), out_fired};

endmodule

@@ src/tlec_ram.sv @@
// ---------------------------------------------------------------------------
// tlec_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlec_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/tlec_checker.sv @@
// ---------------------------------------------------------------------------
// tlec_checker
// port-level checks on the two-level event counter, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "two_level_event_counter_assert.svh"

module tlec_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [tlec_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready
);

  import tlec_pkg::*;

  // a stalled result keeps its value
  `TLEC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // only the fired bit may be set
  `TLEC_ASSERT_IMP(a_out_pad, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:1] == '0, "padding bits set in result")

  // the sequencer is busy in the cycle after each request
  `TLEC_ASSERT_NXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken on consecutive cycles")

  // reset starts the clearing pass with nothing pending
  `TLEC_ASSERT_RST(a_reset_quiet, rst, !s_axis_tready && !m_axis_tvalid, "ready or valid right after reset")

endmodule

bind two_level_event_counter tlec_checker u_tlec_checker (.*);
